>>> design/xfp_pkg.sv
// Shared types and constants for the xor frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package xfp_pkg;

    // frame byte codes
    localparam logic [7:0] SYNC_BYTE     = 8'hA5;
    localparam logic [7:0] TYPE_CODE_MIN = 8'h01;
    localparam logic [7:0] TYPE_CODE_MAX = 8'h04;

    // result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // frame end status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;

    // packed widths on the stream ports
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 16;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] msg_type;
        logic       payload_last;
        logic [1:0] frame_status;
    } result_t;

endpackage

`default_nettype wire

>>> design/xfp_in_stage.sv
// Input register of the xor frame parser: holds one received byte.
// Depends on xfp_pkg.
`default_nettype none

module xfp_in_stage
    import xfp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [IN_TDATA_W-1:0] s_data,
    output logic                       held_valid,
    output logic [7:0]                 held_byte,
    input  wire logic                  take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // space when empty or when the held byte leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // byte holding register
    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            byte_reg <= s_data[7:0];
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

>>> design/xfp_parse.sv
// Frame parsing state machine with running xor and payload count.
// Depends on xfp_pkg.
`default_nettype none

module xfp_parse
    import xfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    output result_t         res
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [1:0] frame_type_reg;
    logic [1:0] frame_type_next;
    logic [7:0] payload_length_reg;
    logic [7:0] payload_length_next;
    logic [7:0] bytes_seen_reg;
    logic [7:0] bytes_seen_next;
    logic [7:0] running_xor_reg;
    logic [7:0] running_xor_next;

    logic       type_ok;
    logic [7:0] type_index;
    logic [7:0] seen_inc;
    logic       is_last;

    assign type_ok    = (rx_byte >= TYPE_CODE_MIN) && (rx_byte <= TYPE_CODE_MAX);
    assign type_index = rx_byte - TYPE_CODE_MIN;
    assign seen_inc   = bytes_seen_reg + 8'd1;
    assign is_last    = (seen_inc >= payload_length_reg);

    // next state and datapath
    always_comb
    begin
        phase_next          = phase_reg;
        frame_type_next     = frame_type_reg;
        payload_length_next = payload_length_reg;
        bytes_seen_next     = bytes_seen_reg;
        running_xor_next    = running_xor_reg;
        unique case (phase_reg)
            PH_TYPE:
            begin
                running_xor_next = running_xor_reg ^ rx_byte;
                if (type_ok)
                begin
                    frame_type_next = type_index[1:0];
                    phase_next      = PH_LEN;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                running_xor_next    = running_xor_reg ^ rx_byte;
                payload_length_next = rx_byte;
                bytes_seen_next     = 8'd0;
                phase_next          = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                running_xor_next = running_xor_reg ^ rx_byte;
                bytes_seen_next  = seen_inc;
                if (is_last)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                // hunting, also unused codes
                if (rx_byte == SYNC_BYTE)
                begin
                    running_xor_next    = SYNC_BYTE;
                    frame_type_next     = 2'd0;
                    payload_length_next = 8'd0;
                    bytes_seen_next     = 8'd0;
                    phase_next          = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // result for the byte being parsed
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.data_byte    = 8'd0;
        res.msg_type     = 2'd0;
        res.payload_last = 1'b0;
        res.frame_status = STATUS_OK;
        unique case (phase_reg)
            PH_TYPE:
            begin
                if (!type_ok)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_FRAME_END;
                    res.frame_status = STATUS_BAD_TYPE;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.data_byte    = rx_byte;
                res.msg_type     = frame_type_reg;
                res.payload_last = is_last;
            end
            PH_CHECK:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_FRAME_END;
                res.msg_type     = frame_type_reg;
                res.frame_status = (rx_byte == running_xor_reg) ? STATUS_OK : STATUS_BAD_SUM;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // state registers advance once per parsed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            frame_type_reg     <= 2'd0;
            payload_length_reg <= 8'd0;
            bytes_seen_reg     <= 8'd0;
            running_xor_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            frame_type_reg     <= frame_type_next;
            payload_length_reg <= payload_length_next;
            bytes_seen_reg     <= bytes_seen_next;
            running_xor_reg    <= running_xor_next;
        end
    end

endmodule

`default_nettype wire

>>> design/xfp_out_stage.sv
// Result register of the xor frame parser, drives the master stream side.
// Depends on xfp_pkg.
`default_nettype none

module xfp_out_stage
    import xfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire result_t                res,
    output logic                        room,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [OUT_TDATA_W-1:0]      m_data,
    output logic                        m_user,
    output logic                        m_last
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // free when empty or when the held result is taken this cycle
    assign room = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            res_reg <= res;
        end
    end

    // pack fields onto the stream
    assign m_valid = valid_reg;
    assign m_data  = {4'd0, res_reg.frame_status, res_reg.msg_type, res_reg.data_byte};
    assign m_user  = res_reg.kind;
    assign m_last  = res_reg.payload_last;

endmodule

`default_nettype wire

>>> design/xor_frame_parser.sv
// Top level of the xor frame parser: input register, parser, result register.
// Depends on xfp_pkg, xfp_in_stage, xfp_parse and xfp_out_stage.
//
//   channel  | direction | transaction
//   s_axis   | in        | one received byte
//   m_axis   | out       | one payload byte or one frame end with status
//
// One byte per cycle sustained while m_axis is ready; a byte is held in the input
// register and its result in the result register before it leaves on m_axis.
// Reset puts the parser in start byte hunt with empty registers.
// A stall on m_axis holds the result register; the input register still takes
// one byte, then s_axis_tready drops until the result is taken.
`default_nettype none

module xor_frame_parser
    import xfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] msg_type,
                                                        // [11:10] frame_status, [15:12] zero
    output logic                        m_axis_tuser,   // result_kind
    output logic                        m_axis_tlast    // payload_last
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       take;
    logic       room;
    logic       res_valid;
    result_t    res;

    // a held byte moves on when the result register has room
    assign take = held_valid && room;

    xfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .take       (take)
    );

    xfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .rx_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    xfp_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (take && res_valid),
        .res     (res),
        .room    (room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_user  (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/xfp_frame_checker.sv
// Transaction checker for the xor frame parser: watches both stream channels,
// predicts each result from the accepted bytes and compares in order.
// Depends on xfp_pkg for the phase enum, result struct and code constants.
module xfp_frame_checker
    import xfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [9:8] msg_type,
                                                   // [11:10] frame_status, [15:12] zero
    input  logic                   m_axis_tuser,   // result_kind
    input  logic                   m_axis_tlast,   // payload_last
    output int                     fail_count,
    output int                     results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // parser state as the predictor sees it
    phase_t     rx_phase;
    logic [1:0] rx_type;
    logic [7:0] rx_length;
    logic [7:0] rx_count;
    logic [7:0] rx_xor;

    result_t expected_results[$];
    int      reports_shown;

    // advance the frame parser by one byte, queue the result it produces
    task automatic parse_rx_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (rx_phase)
            PH_TYPE:
            begin
                rx_xor = rx_xor ^ b;
                if (b >= TYPE_CODE_MIN && b <= TYPE_CODE_MAX)
                begin
                    // codes 1..4 map to 0..3
                    rx_type  = b[1:0] - 2'd1;
                    rx_phase = PH_LEN;
                end
                else
                begin
                    rx_phase         = PH_HUNT;
                    r.kind           = KIND_FRAME_END;
                    r.frame_status   = STATUS_BAD_TYPE;
                    expected_results = {expected_results, r};
                end
            end
            PH_LEN:
            begin
                rx_xor    = rx_xor ^ b;
                rx_length = b;
                rx_count  = 8'd0;
                rx_phase  = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                rx_xor   = rx_xor ^ b;
                rx_count = rx_count + 8'd1;
                r.kind      = KIND_PAYLOAD;
                r.data_byte = b;
                r.msg_type  = rx_type;
                if (rx_count >= rx_length)
                begin
                    r.payload_last = 1'b1;
                    rx_phase       = PH_CHECK;
                end
                expected_results = {expected_results, r};
            end
            PH_CHECK:
            begin
                rx_phase         = PH_HUNT;
                r.kind           = KIND_FRAME_END;
                r.msg_type       = rx_type;
                r.frame_status   = (b == rx_xor) ? STATUS_OK : STATUS_BAD_SUM;
                expected_results = {expected_results, r};
            end
            default:
            begin
                // hunting: only the sync byte opens a frame
                if (b == SYNC_BYTE)
                begin
                    rx_xor    = SYNC_BYTE;
                    rx_type   = 2'd0;
                    rx_length = 8'd0;
                    rx_count  = 8'd0;
                    rx_phase  = PH_TYPE;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                end
            end
        endcase
    endtask

    // compare one output transaction with the oldest expectation
    task automatic check_result();
        result_t exp_r;
        result_t got_r;
        bit      bad;
        got_r.kind         = m_axis_tuser;
        got_r.data_byte    = m_axis_tdata[7:0];
        got_r.msg_type     = m_axis_tdata[9:8];
        got_r.frame_status = m_axis_tdata[11:10];
        got_r.payload_last = m_axis_tlast;
        if (expected_results.size() == 0)
        begin
            fail_count = fail_count + 1;
            if (reports_shown < 10)
            begin
                reports_shown = reports_shown + 1;
                $display("%t unexpected result: kind=%b data=%h type=%0d last=%b status=%0d",
                         $realtime, got_r.kind, got_r.data_byte, got_r.msg_type,
                         got_r.payload_last, got_r.frame_status);
            end
            return;
        end
        exp_r = expected_results.pop_front();
        bad = (got_r.kind !== exp_r.kind)
            || (got_r.data_byte !== exp_r.data_byte)
            || (got_r.msg_type !== exp_r.msg_type)
            || (got_r.frame_status !== exp_r.frame_status)
            || (got_r.payload_last !== exp_r.payload_last)
            || (m_axis_tdata[15:12] !== 4'd0);
        if (bad)
        begin
            fail_count = fail_count + 1;
            if (reports_shown < 10)
            begin
                reports_shown = reports_shown + 1;
                $display("%t result mismatch: expected kind=%b data=%h type=%0d last=%b status=%0d",
                         $realtime, exp_r.kind, exp_r.data_byte, exp_r.msg_type,
                         exp_r.payload_last, exp_r.frame_status);
                $display("%t   actual kind=%b data=%h type=%0d last=%b status=%0d pad=%h",
                         $realtime, got_r.kind, got_r.data_byte, got_r.msg_type,
                         got_r.payload_last, got_r.frame_status, m_axis_tdata[15:12]);
            end
        end
    endtask

    // sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase  <= PH_HUNT;
            rx_type   <= 2'd0;
            rx_length <= 8'd0;
            rx_count  <= 8'd0;
            rx_xor    <= 8'd0;
            expected_results.delete();
            fail_count      <= 0;
            results_pending <= 0;
            reports_shown   <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_rx_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            results_pending <= expected_results.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the xor frame parser testbench: clock, reset, byte stimulus,
// random backpressure and the final verdict.
// Depends on xfp_pkg, xor_frame_parser and xfp_frame_checker.
module testbench;
    import xfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [7:0] data_byte, [9:8] msg_type,
                                            // [11:10] frame_status, [15:12] zero
    logic                   m_axis_tuser;   // result_kind
    logic                   m_axis_tlast;   // payload_last

    int fail_count;
    int results_pending;
    int bytes_counted;

    xor_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    xfp_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        int cycle_no;
        cycle_no = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no = cycle_no + 1;
            if (cycle_no >= 1100 && cycle_no < 1400)
                m_axis_tready <= 1'b0;
            else if (cycle_no >= 400 && cycle_no < 800)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b, input bit counted);
        bit accepted;
        bit calm;
        calm = (bytes_counted >= 500 && bytes_counted < 800);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_axis_tready;
            @(posedge clk);
        end
        if (counted)
            bytes_counted = bytes_counted + 1;
    endtask

    // well-formed frame with random payload, optionally with a bad checksum
    task automatic send_frame(input logic [7:0] type_code, input logic [7:0] len,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] pb;
        sum = SYNC_BYTE ^ type_code ^ len;
        send_byte(SYNC_BYTE, 1'b1);
        send_byte(type_code, 1'b1);
        send_byte(len, 1'b1);
        for (int i = 0; i < len; i++)
        begin
            pb  = 8'($urandom_range(0, 255));
            sum = sum ^ pb;
            send_byte(pb, 1'b1);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum, 1'b1);
    endtask

    // stimulus and verdict
    initial
    begin
        logic [7:0] directed_bytes[$];
        logic [7:0] len;
        logic [7:0] bad_code;
        int         pick;
        int         wait_cycles;

        // noise, zero length, type 4 with extreme payload, three bad types,
        // checksum mismatch, sync byte inside a payload
        directed_bytes = '{8'h00, 8'hFF,
                           8'hA5, 8'h01, 8'h00, 8'hA4,
                           8'hA5, 8'h04, 8'h02, 8'h00, 8'hFF, 8'h5C,
                           8'hA5, 8'h00,
                           8'hA5, 8'h05,
                           8'hA5, 8'hFF,
                           8'hA5, 8'h02, 8'h01, 8'h37, 8'h90,
                           8'hA5, 8'h03, 8'h01, 8'hA5, 8'h02};

        bytes_counted = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i], 1'b1);

        // random frames, mostly well formed, some noise and bad types
        while (bytes_counted < 1450)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 18)
            begin
                bad_code = ($urandom_range(0, 3) == 0) ? 8'h00
                                                       : 8'($urandom_range(5, 255));
                send_byte(SYNC_BYTE, 1'b1);
                send_byte(bad_code, 1'b1);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    len = ($urandom_range(0, 1) == 0) ? 8'hFF
                                                      : 8'($urandom_range(128, 255));
                else if (pick < 13)
                    len = 8'd0;
                else
                    len = 8'($urandom_range(1, 12));
                send_frame(8'($urandom_range(1, 4)), len, ($urandom_range(0, 99) < 12));
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        repeat (4) @(posedge clk);
        wait_cycles = 0;
        while (results_pending != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles = wait_cycles + 1;
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0 && results_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
design/xfp_pkg.sv
design/xfp_in_stage.sv
design/xfp_parse.sv
design/xfp_out_stage.sv
design/xor_frame_parser.sv
tb/xfp_frame_checker.sv
tb/testbench.sv
